// ----- rtl/lbu_pkg.sv -----
// ----------------------------------------------------------------------------
// lbu_pkg: shared types and constants of the layer-2 packet bit unpacker
// Holds the classified byte item passed from front to back, the packet kind
// and status codes, and the entry width lookup.
// ----------------------------------------------------------------------------
package lbu_pkg;

   // packet kind codes
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_W24  = 2'd1;
   localparam logic [1:0] KIND_W47  = 2'd2;
   localparam logic [1:0] KIND_W64  = 2'd3;

   // end-of-packet status codes
   localparam logic [1:0] ST_PROGRESS  = 2'd0;
   localparam logic [1:0] ST_ACCEPTED  = 2'd1;
   localparam logic [1:0] ST_SHORT     = 2'd2;
   localparam logic [1:0] ST_UNKNOWN   = 2'd3;

   // type code bytes
   localparam logic [7:0] CODE_W24_HI = 8'h1d;
   localparam logic [7:0] CODE_W24_LO = 8'h1a;
   localparam logic [7:0] CODE_W47_HI = 8'h0c;
   localparam logic [7:0] CODE_W47_LO = 8'haa;
   localparam logic [7:0] CODE_W64_HI = 8'h0e;
   localparam logic [7:0] CODE_W64_LO = 8'h55;

   // byte positions in the header
   localparam logic [2:0] IDX_DEST_HI = 3'd0;
   localparam logic [2:0] IDX_DEST_LO = 3'd1;
   localparam logic [2:0] IDX_SUB_HI  = 3'd2;
   localparam logic [2:0] IDX_SUB_LO  = 3'd3;
   localparam logic [2:0] IDX_CODE_HI = 3'd4;
   localparam logic [2:0] IDX_CODE_LO = 3'd5;
   localparam logic [2:0] IDX_DATA    = 3'd6;
   localparam logic [2:0] IDX_MAX     = 3'd7;

   localparam int unsigned NEED_W = 7;
   localparam logic [NEED_W-1:0] MAX_WIDTH = 7'd64;

   // depth of the queue between front and back
   localparam int unsigned QDEPTH = 2;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_LOAD,
      OP_UNPACK
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [1:0]  kind;
      logic [15:0] dest_id;
      logic [15:0] sub_destination;
      logic [1:0]  packet_kind;
      logic [1:0]  status;
   } item_type;

   function automatic logic [NEED_W-1:0] kind_width(input logic [1:0] kind);
      logic [NEED_W-1:0] w;
      case (kind)
         KIND_W24: w = 7'd24;
         KIND_W47: w = 7'd47;
         KIND_W64: w = 7'd64;
         default:  w = 7'd0;
      endcase
      return w;
   endfunction

   function automatic logic [1:0] decode_kind(input logic [7:0] hi, input logic [7:0] lo);
      logic [1:0] k;
      k = KIND_NONE;
      if (hi == CODE_W24_HI && lo == CODE_W24_LO) k = KIND_W24;
      else if (hi == CODE_W47_HI && lo == CODE_W47_LO) k = KIND_W47;
      else if (hi == CODE_W64_HI && lo == CODE_W64_LO) k = KIND_W64;
      return k;
   endfunction

endpackage

// ----- rtl/lbu_front.sv -----
// ----------------------------------------------------------------------------
// lbu_front: header parser
// Tracks the byte position, gathers the ids and type code, and tags each
// request with the work the back end has to do for it.
// ----------------------------------------------------------------------------
module lbu_front
   import lbu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       req_push,
   output logic       req_full,
   input  logic       q_full,
   output logic       q_push,
   output item_type   q_item
);

   logic [2:0]  idx_ff, idx_in;
   logic [15:0] dest_ff, dest_in;
   logic [15:0] sub_ff, sub_in;
   logic [7:0]  code_hi_ff, code_hi_in;
   logic [1:0]  kind_ff, kind_in;
   logic        rejected_ff, rejected_in;
   logic        accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign q_push   = accept;

   always_comb begin
      dest_in     = dest_ff;
      sub_in      = sub_ff;
      code_hi_in  = code_hi_ff;
      kind_in     = kind_ff;
      rejected_in = rejected_ff;
      q_item.op   = OP_HOLD;
      case (idx_ff)
         IDX_DEST_HI: dest_in = {req_data_byte, 8'h00};
         IDX_DEST_LO: dest_in = {dest_ff[15:8], req_data_byte};
         IDX_SUB_HI:  sub_in  = {req_data_byte, 8'h00};
         IDX_SUB_LO:  sub_in  = {sub_ff[15:8], req_data_byte};
         IDX_CODE_HI: code_hi_in = req_data_byte;
         IDX_CODE_LO: begin
            kind_in     = decode_kind(code_hi_ff, req_data_byte);
            rejected_in = (kind_in == KIND_NONE);
            q_item.op   = OP_LOAD;
         end
         default: begin
            if (!rejected_ff && kind_ff != KIND_NONE) q_item.op = OP_UNPACK;
         end
      endcase

      q_item.data_byte       = req_data_byte;
      q_item.last_byte       = req_last_byte;
      q_item.kind            = kind_in;
      q_item.dest_id         = dest_in;
      q_item.sub_destination = sub_in;
      q_item.packet_kind     = kind_in;
      q_item.status          = ST_PROGRESS;
      if (req_last_byte) begin
         if (idx_ff <= IDX_CODE_LO) begin
            q_item.status      = ST_SHORT;
            q_item.packet_kind = KIND_NONE;
         end else if (rejected_ff) begin
            q_item.status      = ST_UNKNOWN;
            q_item.packet_kind = KIND_NONE;
         end else begin
            q_item.status      = ST_ACCEPTED;
         end
      end

      idx_in = (idx_ff == IDX_MAX) ? idx_ff : idx_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= IDX_DEST_HI;
         dest_ff     <= '0;
         sub_ff      <= '0;
         code_hi_ff  <= '0;
         kind_ff     <= KIND_NONE;
         rejected_ff <= 1'b0;
      end else if (accept) begin
         if (req_last_byte) begin
            // start over with a fresh packet
            idx_ff      <= IDX_DEST_HI;
            dest_ff     <= '0;
            sub_ff      <= '0;
            code_hi_ff  <= '0;
            kind_ff     <= KIND_NONE;
            rejected_ff <= 1'b0;
         end else begin
            idx_ff      <= idx_in;
            dest_ff     <= dest_in;
            sub_ff      <= sub_in;
            code_hi_ff  <= code_hi_in;
            kind_ff     <= kind_in;
            rejected_ff <= rejected_in;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (idx_ff >= IDX_DATA && kind_ff == KIND_NONE) |-> rejected_ff)
      else $error("lbu_front: data byte with no kind and no reject");

endmodule

// ----- rtl/lbu_queue.sv -----
// ----------------------------------------------------------------------------
// lbu_queue: short queue between front and back
// Holds classified requests so each side can stall on its own. Full is
// registered so it does not depend on the far side in the same cycle.
// ----------------------------------------------------------------------------
module lbu_queue
   import lbu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type head_item
);

   item_type            slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push;
   logic                do_pop;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("lbu_queue: count beyond depth");

endmodule

// ----- rtl/lbu_back.sv -----
// ----------------------------------------------------------------------------
// lbu_back: entry unpacker and result register
// Shifts data bytes MSB first into the entry accumulator and emits each entry
// on the byte that completes it. The result register decouples the consumer.
// ----------------------------------------------------------------------------
module lbu_back
   import lbu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_entry_valid,
   output logic [63:0] rsp_entry_value,
   output logic [15:0] rsp_dest_id,
   output logic [15:0] rsp_sub_destination,
   output logic [1:0]  rsp_packet_kind,
   output logic [1:0]  rsp_status,
   output logic        rsp_packet_end,
   output logic        rsp_empty,
   input  logic        rsp_pop
);

   logic [63:0]       acc_ff, acc_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic              rsp_valid_ff;
   logic              entry_valid_ff, entry_valid_in;
   logic [63:0]       entry_value_ff, entry_value_in;
   logic [15:0]       dest_ff;
   logic [15:0]       sub_ff;
   logic [1:0]        kind_ff;
   logic [1:0]        status_ff;
   logic              end_ff;

   logic              fire;
   logic [NEED_W-1:0] width;
   logic [NEED_W-1:0] need_eff;
   logic [NEED_W-1:0] need_rem;
   logic [63:0]       acc_or;
   logic [3:0]        rest;
   logic [7:0]        low_bits;

   assign fire  = !q_empty && (!rsp_valid_ff || rsp_pop);
   assign q_pop = fire;

   always_comb begin
      width    = kind_width(q_item.kind);
      need_eff = (need_ff == '0 || need_ff > width) ? width : need_ff;
      need_rem = need_eff - NEED_W'(8);
      acc_or   = acc_ff | ({56'd0, q_item.data_byte} << need_rem);
      rest     = 4'd8 - {1'b0, need_eff[2:0]};
      low_bits = q_item.data_byte & (8'hff >> need_eff[2:0]);

      acc_in         = acc_ff;
      need_in        = need_ff;
      entry_valid_in = 1'b0;
      entry_value_in = '0;
      case (q_item.op)
         OP_LOAD: begin
            acc_in  = '0;
            need_in = width;
         end
         OP_UNPACK: begin
            if (need_eff >= NEED_W'(8)) begin
               if (need_rem == '0) begin
                  entry_valid_in = 1'b1;
                  entry_value_in = acc_or;
                  acc_in         = '0;
                  need_in        = width;
               end else begin
                  acc_in  = acc_or;
                  need_in = need_rem;
               end
            end else begin
               // entry ends inside this byte: spill the low bits into the next one
               entry_valid_in = 1'b1;
               entry_value_in = acc_ff | {56'd0, q_item.data_byte >> rest};
               need_in        = width - {3'd0, rest};
               acc_in         = {56'd0, low_bits} << need_in;
            end
         end
         default: ;
      endcase
      if (q_item.last_byte) begin
         // drop any partial entry
         acc_in  = '0;
         need_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         need_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            acc_ff  <= acc_in;
            need_ff <= need_in;
         end
         if (fire) rsp_valid_ff <= 1'b1;
         else if (rsp_pop) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         entry_valid_ff <= entry_valid_in;
         entry_value_ff <= entry_value_in;
         dest_ff        <= q_item.dest_id;
         sub_ff         <= q_item.sub_destination;
         kind_ff        <= q_item.packet_kind;
         status_ff      <= q_item.status;
         end_ff         <= q_item.last_byte;
      end
   end

   assign rsp_empty           = !rsp_valid_ff;
   assign rsp_entry_valid     = entry_valid_ff;
   assign rsp_entry_value     = entry_value_ff;
   assign rsp_dest_id         = dest_ff;
   assign rsp_sub_destination = sub_ff;
   assign rsp_packet_kind     = kind_ff;
   assign rsp_status          = status_ff;
   assign rsp_packet_end      = end_ff;

   assert property (@(posedge clock) disable iff (reset)
      need_ff <= MAX_WIDTH)
      else $error("lbu_back: bit count beyond widest entry");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && entry_valid_ff) |-> (kind_ff != KIND_NONE))
      else $error("lbu_back: entry emitted for unknown kind");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (end_ff == (status_ff != ST_PROGRESS)))
      else $error("lbu_back: status and packet end disagree");

   assert property (@(posedge clock) disable iff (reset)
      (fire && q_item.last_byte) |=> (need_ff == '0 && acc_ff == '0))
      else $error("lbu_back: unpack state not cleared at packet end");

endmodule

// ----- rtl/layer2_packet_bit_unpacker.sv -----
// ----------------------------------------------------------------------------
// layer2_packet_bit_unpacker: byte-serial packet header parser and entry unpacker
//
//   channel | ports                        | accepted when
//   --------+------------------------------+--------------------------
//   request | req_data_byte, req_last_byte | req_push && !req_full
//   result  | rsp_* fields                 | rsp_pop && !rsp_empty
//
// One request per clock sustained while the consumer keeps popping; each request yields exactly one result.
// A result reaches the ports through a queue slot, then the result register; the parser
// in front of the queue is combinational.
// The front parser and the back unpacker are joined by a two-entry queue; full
// comes only from that queue and empty only from the result register.
// Synchronous reset clears the byte position, ids, kind, accumulator, queue and result valid.
// A stalled consumer fills the result register, then the queue, then asserts full.
// ----------------------------------------------------------------------------
module layer2_packet_bit_unpacker
   import lbu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        req_push,
   output logic        req_full,
   output logic        rsp_entry_valid,
   output logic [63:0] rsp_entry_value,
   output logic [15:0] rsp_dest_id,
   output logic [15:0] rsp_sub_destination,
   output logic [1:0]  rsp_packet_kind,
   output logic [1:0]  rsp_status,
   output logic        rsp_packet_end,
   output logic        rsp_empty,
   input  logic        rsp_pop
);

   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_empty;
   item_type front_item;
   item_type head_item;

   lbu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .req_push      (req_push),
      .req_full      (req_full),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (front_item)
   );

   lbu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_item (head_item)
   );

   lbu_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_item              (head_item),
      .q_pop               (q_pop),
      .rsp_entry_valid     (rsp_entry_valid),
      .rsp_entry_value     (rsp_entry_value),
      .rsp_dest_id         (rsp_dest_id),
      .rsp_sub_destination (rsp_sub_destination),
      .rsp_packet_kind     (rsp_packet_kind),
      .rsp_status          (rsp_status),
      .rsp_packet_end      (rsp_packet_end),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop)
   );

endmodule
